### rtl/vn_pkg.sv
package vn_pkg;

  // default component width and fraction bits
  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // number of vector components
  localparam int LANES = 3;

endpackage

### rtl/vn_in_if.sv
interface vn_in_if #(
  parameter int COMP_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_x;
  logic signed [COMP_WIDTH-1:0] comp_y;
  logic signed [COMP_WIDTH-1:0] comp_z;

  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

### rtl/vn_out_if.sv
interface vn_out_if #(
  parameter int OUT_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] unit_x;
  logic signed [OUT_WIDTH-1:0] unit_y;
  logic signed [OUT_WIDTH-1:0] unit_z;
  logic                        zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

### rtl/vn_prep.sv
module vn_prep
  import vn_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int SW = 2 * COMP_WIDTH,
  localparam int YW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                valid_i,
  input  logic [LANES-1:0][COMP_WIDTH-1:0]    comp_i,
  output logic                                valid_o,
  output logic [SW-1:0]                       s_o,
  output logic [LANES-1:0][YW-1:0]            r_o,
  output logic [LANES-1:0]                    neg_o,
  output logic                                zero_o
);

  logic                             v1;
  logic [LANES-1:0][SW-1:0]         sq;
  logic [LANES-1:0]                 neg1;
  logic [LANES-1:0][COMP_WIDTH-1:0] mag;
  logic [SW-1:0]                    s_sum;

  // magnitudes of the components
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = comp_i[l][COMP_WIDTH-1] ? (~comp_i[l] + 1'b1) : comp_i[l];
    end
  end

  // stage one: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        sq[l]   <= SW'(mag[l]) * SW'(mag[l]);
        neg1[l] <= comp_i[l][COMP_WIDTH-1];
      end
    end
  end

  assign s_sum = sq[0] + sq[1] + sq[2];

  // stage two: sum of squares and per-lane bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_o    <= s_sum;
      zero_o <= (s_sum == '0);
      neg_o  <= neg1;
      for (int l = 0; l < LANES; l++) begin
        r_o[l] <= YW'(sq[l]) << (2 * FRAC_BITS + 2);
      end
    end
  end

endmodule

### rtl/vn_step.sv
module vn_step
  import vn_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int BIT        = 0,
  localparam int SW = 2 * COMP_WIDTH,
  localparam int YW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 6,
  localparam int QW = FRAC_BITS + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic [SW-1:0]                   s_i,
  input  logic [LANES-1:0][YW-1:0]        r_i,
  input  logic [LANES-1:0][YW-1:0]        x_i,
  input  logic [LANES-1:0][YW-1:0]        y_i,
  input  logic [LANES-1:0][QW-1:0]        q_i,
  input  logic [LANES-1:0]                neg_i,
  input  logic                            zero_i,
  output logic                            valid_o,
  output logic [SW-1:0]                   s_o,
  output logic [LANES-1:0][YW-1:0]        r_o,
  output logic [LANES-1:0][YW-1:0]        x_o,
  output logic [LANES-1:0][YW-1:0]        y_o,
  output logic [LANES-1:0][QW-1:0]        q_o,
  output logic [LANES-1:0]                neg_o,
  output logic                            zero_o
);

  logic signed [YW-1:0]      s_ext;
  logic signed [YW-1:0]      y_try [LANES];
  logic        [LANES-1:0]   take;

  assign s_ext = YW'(s_i);

  // try setting this bit: y = t*t*s, x = t*s with t = 2q-1
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      y_try[l] = $signed(y_i[l]) + ($signed(x_i[l]) <<< (BIT + 2))
               + (s_ext <<< (2 * BIT + 2));
      take[l]  = (y_try[l] <= $signed(r_i[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_o    <= s_i;
      r_o    <= r_i;
      neg_o  <= neg_i;
      zero_o <= zero_i;
      for (int l = 0; l < LANES; l++) begin
        if (take[l]) begin
          y_o[l] <= y_try[l];
          x_o[l] <= $signed(x_i[l]) + (s_ext <<< (BIT + 1));
          q_o[l] <= q_i[l] | (QW'(1) << BIT);
        end else begin
          y_o[l] <= y_i[l];
          x_o[l] <= x_i[l];
          q_o[l] <= q_i[l];
        end
      end
    end
  end

endmodule

### rtl/vector3_normalize.sv
// vector3_normalize: scales a signed 3d vector to a unit vector in q1.14
// throughput: one beat per cycle while the output slot is free or being taken;
// one shift-add step per quotient bit, in FRAC_BITS + 1 stages, plus two
// front stages and one output register
// reset: rst (synchronous) clears all valid bits; payload is not reset
module vector3_normalize
  import vn_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  vn_in_if.sink    vec_in,
  vn_out_if.source vec_out
);

  localparam int SW = 2 * COMP_WIDTH;
  localparam int YW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 6;
  localparam int QW = FRAC_BITS + 1;
  localparam int OW = FRAC_BITS + 2;
  localparam int NS = FRAC_BITS + 2;

  logic                     adv;
  logic                     pv   [NS];
  logic [SW-1:0]            ps   [NS];
  logic [LANES-1:0][YW-1:0] pr   [NS];
  logic [LANES-1:0][YW-1:0] px   [NS];
  logic [LANES-1:0][YW-1:0] py   [NS];
  logic [LANES-1:0][QW-1:0] pq   [NS];
  logic [LANES-1:0]         pneg [NS];
  logic                     pz   [NS];
  logic [LANES-1:0][OW-1:0] unit_res;

  // whole pipe moves when the output slot is free or being taken
  assign adv          = !vec_out.valid || vec_out.ready;
  assign vec_in.ready = adv;

  vn_prep #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .valid_i (vec_in.valid),
    .comp_i  ({vec_in.comp_z, vec_in.comp_y, vec_in.comp_x}),
    .valid_o (pv[0]),
    .s_o     (ps[0]),
    .r_o     (pr[0]),
    .neg_o   (pneg[0]),
    .zero_o  (pz[0])
  );

  // search starts at q = 0, i.e. t = -1
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      px[0][l] = -YW'(ps[0]);
      py[0][l] = YW'(ps[0]);
      pq[0][l] = '0;
    end
  end

  // one stage per quotient bit, msb first
  for (genvar g = 0; g < QW; g++) begin : g_step
    vn_step #(
      .COMP_WIDTH (COMP_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .BIT        (FRAC_BITS - g)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .valid_i (pv[g]),
      .s_i     (ps[g]),
      .r_i     (pr[g]),
      .x_i     (px[g]),
      .y_i     (py[g]),
      .q_i     (pq[g]),
      .neg_i   (pneg[g]),
      .zero_i  (pz[g]),
      .valid_o (pv[g+1]),
      .s_o     (ps[g+1]),
      .r_o     (pr[g+1]),
      .x_o     (px[g+1]),
      .y_o     (py[g+1]),
      .q_o     (pq[g+1]),
      .neg_o   (pneg[g+1]),
      .zero_o  (pz[g+1])
    );
  end

  // apply signs, force zero vector
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (pz[NS-1]) begin
        unit_res[l] = '0;
      end else if (pneg[NS-1][l]) begin
        unit_res[l] = -OW'(pq[NS-1][l]);
      end else begin
        unit_res[l] = OW'(pq[NS-1][l]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else if (adv) begin
      vec_out.valid <= pv[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_out.unit_x      <= unit_res[0];
      vec_out.unit_y      <= unit_res[1];
      vec_out.unit_z      <= unit_res[2];
      vec_out.zero_length <= pz[NS-1];
    end
  end

  localparam logic signed [OW-1:0] UNIT_MAX = OW'(1) << FRAC_BITS;

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    vec_out.valid && vec_out.zero_length |->
      vec_out.unit_x == '0 && vec_out.unit_y == '0 && vec_out.unit_z == '0)
    else $error("zero-length beat with nonzero unit vector");

  a_range_x: assert property (@(posedge clk) disable iff (rst)
    vec_out.valid |-> vec_out.unit_x <= UNIT_MAX && vec_out.unit_x >= -UNIT_MAX)
    else $error("unit_x out of range");

  a_range_y: assert property (@(posedge clk) disable iff (rst)
    vec_out.valid |-> vec_out.unit_y <= UNIT_MAX && vec_out.unit_y >= -UNIT_MAX)
    else $error("unit_y out of range");

  a_range_z: assert property (@(posedge clk) disable iff (rst)
    vec_out.valid |-> vec_out.unit_z <= UNIT_MAX && vec_out.unit_z >= -UNIT_MAX)
    else $error("unit_z out of range");

endmodule
